### rtl/wosa_pkg.sv
// Shared types and constants for the weighted OSA edit distance block.
`default_nettype none

package wosa_pkg;

    localparam int unsigned SYMBOL_W = 8;
    localparam int unsigned COST_W   = 8;
    localparam int unsigned DIST_W   = 15;
    localparam int unsigned REG_IDX_W = 3;

    localparam logic [DIST_W-1:0] DIST_MAX = 15'h7FFF;

    // Item kinds
    localparam logic [1:0] KIND_FIRST   = 2'd0;
    localparam logic [1:0] KIND_SECOND  = 2'd1;
    localparam logic [1:0] KIND_COMPUTE = 2'd2;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_INSERT     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SUBSTITUTE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DELETE     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TRANSPOSE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TR_ENABLE  = 3'd4;

    typedef struct packed {
        logic [1:0]          kind;
        logic [SYMBOL_W-1:0] symbol;
    } in_word_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } out_word_t;

    typedef struct packed {
        logic [COST_W-1:0] insert_cost;
        logic [COST_W-1:0] substitute_cost;
        logic [COST_W-1:0] delete_cost;
        logic [COST_W-1:0] transpose_cost;
        logic              transpose_enable;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW_NEXT,
        ST_ROW_HEAD,
        ST_CELL_RD,
        ST_CELL_CALC,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_APPEND,
        OP_START,
        OP_INIT,
        OP_ROW_NEXT,
        OP_ROW_HEAD,
        OP_CELL_RD,
        OP_CELL_CALC,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t  op;
        logic to_second;
    } cmd_t;

    typedef struct packed {
        logic col_last;
        logic rows_done;
        logic second_empty;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

### rtl/weighted_osa_edit_distance_top.sv
// Top level of the weighted OSA edit distance block: register file, sequencer and datapath.
//
// Usage: in_data words with kind 0 append symbol to the first string, kind 1 append it
// to the second. Bytes beyond MAX_LEN are dropped and flagged. A kind 2 word starts the
// computation; kind 3 is taken and ignored. in_stall is high from the compute word until
// the result has been placed in the output register.
// Sequence: the top row is written column by column, then each row has a row set-up
// (row advance, row head) and, per column, a score row read, then cell update and
// write-back in the three-bank row memory.
// The result word (distance, overflow) sits in an output register until taken; the
// block keeps loading the next strings meanwhile, and a second result waits in the
// sequencer while out_stall holds the first. Both strings are cleared once the result
// is registered.
// Configuration: cfg_ready is always high; write costs only while idle.
// Reset: strings empty, all costs 1, transposition on, no result pending.
`default_nettype none

module weighted_osa_edit_distance_top
    import wosa_pkg::*;
#(
    parameter int unsigned MAX_LEN = 64
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_word_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_word_t                  out_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [REG_IDX_W-1:0]  cfg_index,
    input  wire logic [COST_W-1:0]     cfg_data
);

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.insert_cost      <= COST_W'(1);
            cfg_reg.substitute_cost  <= COST_W'(1);
            cfg_reg.delete_cost      <= COST_W'(1);
            cfg_reg.transpose_cost   <= COST_W'(1);
            cfg_reg.transpose_enable <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_INSERT:     cfg_reg.insert_cost      <= cfg_data;
                REG_SUBSTITUTE: cfg_reg.substitute_cost  <= cfg_data;
                REG_DELETE:     cfg_reg.delete_cost      <= cfg_data;
                REG_TRANSPOSE:  cfg_reg.transpose_cost   <= cfg_data;
                REG_TR_ENABLE:  cfg_reg.transpose_enable <= cfg_data[0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    wosa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (in_data.kind),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    wosa_dpath #(
        .MAX_LEN (MAX_LEN)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .in_data   (in_data),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

### rtl/wosa_ctrl.sv
// Sequencer for string loading and the row-by-row score sweep.
`default_nettype none

module wosa_ctrl
    import wosa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] kind,
    input  wire stat_t      stat,
    output logic            in_stall,
    output cmd_t            cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd.op        = OP_NONE;
        cmd.to_second = 1'b0;
        in_stall      = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    priority if (kind == KIND_COMPUTE)
                    begin
                        cmd.op     = OP_START;
                        state_next = ST_INIT;
                    end
                    else if (kind == KIND_FIRST)
                    begin
                        cmd.op = OP_APPEND;
                    end
                    else if (kind == KIND_SECOND)
                    begin
                        cmd.op        = OP_APPEND;
                        cmd.to_second = 1'b1;
                    end
                    else
                    begin
                        cmd.op = OP_NONE;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.op = OP_INIT;
                if (stat.col_last)
                begin
                    state_next = ST_ROW_NEXT;
                end
            end
            ST_ROW_NEXT:
            begin
                if (stat.rows_done)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.op     = OP_ROW_NEXT;
                    state_next = ST_ROW_HEAD;
                end
            end
            ST_ROW_HEAD:
            begin
                cmd.op     = OP_ROW_HEAD;
                state_next = stat.second_empty ? ST_ROW_NEXT : ST_CELL_RD;
            end
            ST_CELL_RD:
            begin
                cmd.op     = OP_CELL_RD;
                state_next = ST_CELL_CALC;
            end
            ST_CELL_CALC:
            begin
                cmd.op     = OP_CELL_CALC;
                state_next = stat.col_last ? ST_ROW_NEXT : ST_CELL_RD;
            end
            ST_FINISH:
            begin
                // hold the result until the output register is free
                if (stat.out_free)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_head_after_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROW_HEAD) |-> ($past(state_reg) == ST_ROW_NEXT))
        else $error("row head not preceded by row advance");

    a_calc_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CELL_RD) |=> (state_reg == ST_CELL_CALC))
        else $error("cell read not followed by cell calculation");

endmodule

`default_nettype wire

### rtl/wosa_dpath.sv
// String stores, rotating score rows and the cell update of the edit distance sweep.
`default_nettype none

module wosa_dpath
    import wosa_pkg::*;
#(
    parameter int unsigned MAX_LEN = 64
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire cmd_t      cmd,
    input  wire in_word_t  in_data,
    output stat_t          stat,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_word_t      out_data
);

    localparam int unsigned ROWS    = MAX_LEN + 1;
    localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);
    localparam int unsigned TA_W    = $clog2(MAX_LEN);
    localparam int unsigned SCORE_W = $clog2(2 * MAX_LEN * 255 + 1) + 1;
    localparam int unsigned RA_W    = $clog2(3 * ROWS);
    localparam int unsigned CMP_W   = (SCORE_W > DIST_W) ? SCORE_W : DIST_W;

    // control state
    logic [LEN_W-1:0] first_len_reg, first_len_next;
    logic [LEN_W-1:0] second_len_reg, second_len_next;
    logic             len_ovf_reg, len_ovf_next;
    logic [LEN_W-1:0] i_reg, i_next;
    logic [LEN_W-1:0] j_reg, j_next;
    logic [1:0]       cur_bank_reg, cur_bank_next;
    logic [1:0]       prev_bank_reg, prev_bank_next;
    logic [1:0]       back_bank_reg, back_bank_next;
    logic             out_valid_reg, out_valid_next;

    // payload
    logic [SCORE_W-1:0]  left_reg, left_next;
    logic [SCORE_W-1:0]  diag_reg, diag_next;
    logic [SCORE_W-1:0]  del_acc_reg, del_acc_next;
    logic [SCORE_W-1:0]  last_reg, last_next;
    logic [SYMBOL_W-1:0] a_reg, a_next;
    logic [SYMBOL_W-1:0] a_prev_reg, a_prev_next;
    logic [SYMBOL_W-1:0] b_prev_reg, b_prev_next;
    out_word_t           out_data_reg, out_data_next;

    // memories
    logic [SYMBOL_W-1:0] first_mem  [MAX_LEN];
    logic [SYMBOL_W-1:0] second_mem [MAX_LEN];
    logic [SCORE_W-1:0]  row_mem    [3 * ROWS];
    logic [SYMBOL_W-1:0] first_rd_reg;
    logic [SYMBOL_W-1:0] second_rd_reg;
    logic [SCORE_W-1:0]  up_rd_reg;
    logic [SCORE_W-1:0]  tb_rd_reg;

    logic                first_we, second_we, row_we;
    logic [RA_W-1:0]     row_wa, up_ra, tb_ra;
    logic [SCORE_W-1:0]  row_wd;
    logic [LEN_W-1:0]    j_minus1, tb_col;

    logic [SCORE_W-1:0]  cand_up, cand_left, cand_diag, cand_tr;
    logic [SCORE_W-1:0]  min_a, min_b, cell_score;
    logic                tr_ok;
    logic [CMP_W-1:0]    last_ext;
    logic                dist_sat;

    function automatic logic [RA_W-1:0] bank_base(input logic [1:0] bank);
        logic [RA_W-1:0] base;
        unique case (bank)
            2'd0:    base = '0;
            2'd1:    base = RA_W'(ROWS);
            2'd2:    base = RA_W'(2 * ROWS);
            default: base = '0;
        endcase
        return base;
    endfunction

    // cell update
    always_comb
    begin
        cand_up   = up_rd_reg + SCORE_W'(cfg.delete_cost);
        cand_left = left_reg + SCORE_W'(cfg.insert_cost);
        cand_diag = diag_reg + ((a_reg != second_rd_reg) ?
                                SCORE_W'(cfg.substitute_cost) : '0);
        cand_tr   = tb_rd_reg + SCORE_W'(cfg.transpose_cost);
        tr_ok     = cfg.transpose_enable && (i_reg >= LEN_W'(2)) &&
                    (j_reg >= LEN_W'(2)) && (a_reg == b_prev_reg) &&
                    (a_prev_reg == second_rd_reg);
        min_a     = (cand_up < cand_left) ? cand_up : cand_left;
        min_b     = (tr_ok && (cand_tr < cand_diag)) ? cand_tr : cand_diag;
        cell_score = (min_a < min_b) ? min_a : min_b;
    end

    always_comb
    begin
        j_minus1 = j_reg - LEN_W'(1);
        tb_col   = (j_reg >= LEN_W'(2)) ? (j_reg - LEN_W'(2)) : '0;
        up_ra    = bank_base(prev_bank_reg) + RA_W'(j_reg);
        tb_ra    = bank_base(back_bank_reg) + RA_W'(tb_col);
        row_wa   = bank_base(cur_bank_reg) + RA_W'(j_reg);
        last_ext = CMP_W'(last_reg);
        dist_sat = last_ext > CMP_W'(DIST_MAX);
    end

    always_comb
    begin
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        len_ovf_next    = len_ovf_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        cur_bank_next   = cur_bank_reg;
        prev_bank_next  = prev_bank_reg;
        back_bank_next  = back_bank_reg;
        out_valid_next  = out_valid_reg && out_stall;
        left_next       = left_reg;
        diag_next       = diag_reg;
        del_acc_next    = del_acc_reg;
        last_next       = last_reg;
        a_next          = a_reg;
        a_prev_next     = a_prev_reg;
        b_prev_next     = b_prev_reg;
        out_data_next   = out_data_reg;
        first_we        = 1'b0;
        second_we       = 1'b0;
        row_we          = 1'b0;
        row_wd          = left_reg;

        unique case (cmd.op)
            OP_APPEND:
            begin
                if (!cmd.to_second)
                begin
                    if (first_len_reg < LEN_W'(MAX_LEN))
                    begin
                        first_we       = 1'b1;
                        first_len_next = first_len_reg + LEN_W'(1);
                    end
                    else
                    begin
                        len_ovf_next = 1'b1;
                    end
                end
                else
                begin
                    if (second_len_reg < LEN_W'(MAX_LEN))
                    begin
                        second_we       = 1'b1;
                        second_len_next = second_len_reg + LEN_W'(1);
                    end
                    else
                    begin
                        len_ovf_next = 1'b1;
                    end
                end
            end
            OP_START:
            begin
                i_next         = '0;
                j_next         = '0;
                left_next      = '0;
                del_acc_next   = '0;
                cur_bank_next  = 2'd0;
                prev_bank_next = 2'd1;
                back_bank_next = 2'd2;
            end
            OP_INIT:
            begin
                // top row: left_reg runs as j times the insert cost
                row_we    = 1'b1;
                row_wd    = left_reg;
                last_next = left_reg;
                left_next = left_reg + SCORE_W'(cfg.insert_cost);
                j_next    = j_reg + LEN_W'(1);
            end
            OP_ROW_NEXT:
            begin
                // rotate the three row banks
                back_bank_next = prev_bank_reg;
                prev_bank_next = cur_bank_reg;
                cur_bank_next  = back_bank_reg;
                i_next         = i_reg + LEN_W'(1);
                j_next         = '0;
                diag_next      = del_acc_reg;
                del_acc_next   = del_acc_reg + SCORE_W'(cfg.delete_cost);
                a_prev_next    = a_reg;
            end
            OP_ROW_HEAD:
            begin
                a_next    = first_rd_reg;
                row_we    = 1'b1;
                row_wd    = del_acc_reg;
                left_next = del_acc_reg;
                last_next = del_acc_reg;
                j_next    = LEN_W'(1);
            end
            OP_CELL_RD:
            begin
                j_next = j_reg;
            end
            OP_CELL_CALC:
            begin
                row_we      = 1'b1;
                row_wd      = cell_score;
                left_next   = cell_score;
                last_next   = cell_score;
                diag_next   = up_rd_reg;
                b_prev_next = second_rd_reg;
                j_next      = j_reg + LEN_W'(1);
            end
            OP_FINISH:
            begin
                out_valid_next         = 1'b1;
                out_data_next.distance = dist_sat ? DIST_MAX : last_ext[DIST_W-1:0];
                out_data_next.overflow = len_ovf_reg | dist_sat;
                first_len_next         = '0;
                second_len_next        = '0;
                len_ovf_next           = 1'b0;
            end
            OP_NONE:
            begin
                row_we = 1'b0;
            end
            default:
            begin
                row_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_len_reg  <= '0;
            second_len_reg <= '0;
            len_ovf_reg    <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            cur_bank_reg   <= 2'd0;
            prev_bank_reg  <= 2'd1;
            back_bank_reg  <= 2'd2;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            len_ovf_reg    <= len_ovf_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            cur_bank_reg   <= cur_bank_next;
            prev_bank_reg  <= prev_bank_next;
            back_bank_reg  <= back_bank_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg     <= left_next;
        diag_reg     <= diag_next;
        del_acc_reg  <= del_acc_next;
        last_reg     <= last_next;
        a_reg        <= a_next;
        a_prev_reg   <= a_prev_next;
        b_prev_reg   <= b_prev_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (first_we)
        begin
            first_mem[first_len_reg[TA_W-1:0]] <= in_data.symbol;
        end
        if (second_we)
        begin
            second_mem[second_len_reg[TA_W-1:0]] <= in_data.symbol;
        end
        if (row_we)
        begin
            row_mem[row_wa] <= row_wd;
        end
        if (cmd.op == OP_ROW_NEXT)
        begin
            first_rd_reg <= first_mem[i_reg[TA_W-1:0]];
        end
        if (cmd.op == OP_CELL_RD)
        begin
            second_rd_reg <= second_mem[j_minus1[TA_W-1:0]];
            up_rd_reg     <= row_mem[up_ra];
            tb_rd_reg     <= row_mem[tb_ra];
        end
    end

    always_comb
    begin
        stat.col_last     = (j_reg == second_len_reg);
        stat.rows_done    = (i_reg == first_len_reg);
        stat.second_empty = (second_len_reg == '0);
        stat.out_free     = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (first_len_reg <= LEN_W'(MAX_LEN)) && (second_len_reg <= LEN_W'(MAX_LEN)))
        else $error("string length beyond store depth");

    a_banks_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_bank_reg != prev_bank_reg) && (prev_bank_reg != back_bank_reg) &&
        (cur_bank_reg != back_bank_reg))
        else $error("score row banks overlap");

    a_cell_column: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_CELL_CALC) |-> ((j_reg != '0) && (j_reg <= second_len_reg)))
        else $error("cell column out of range");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FINISH) |=> (out_valid_reg && (first_len_reg == '0)))
        else $error("result not presented after finish");

endmodule

`default_nettype wire
